### sv/irdl_pkg.sv
// Shared types, constants and coefficient tables of the IR distance linearizer.
// Coefficients are rounded to signed Q32 at elaboration from their decimal form.
// No dependencies.
package irdl_pkg;

    // Default parameter values
    localparam int unsigned CHANNELS_DEFAULT    = 5;
    localparam int unsigned SAMPLE_BITS_DEFAULT = 10;
    localparam int unsigned SAMPLE_BITS_MAX     = 12;

    // Field widths
    localparam int unsigned CH_BITS        = 3;
    localparam int unsigned DIST_BITS      = 12;
    localparam int unsigned CURVE_MAP_BITS = 10;
    localparam int unsigned MAP_EXT_BITS   = 16;
    localparam int unsigned ACC_BITS       = 64;
    localparam int unsigned SCALE_BITS     = 10;
    localparam int unsigned DIST_SHIFT     = 28;
    localparam int unsigned PROD_MAX_BITS  = ACC_BITS + SAMPLE_BITS_MAX;
    localparam int unsigned COEF_IDX_BITS  = 5;
    localparam int unsigned COEF_COUNT     = 21;
    localparam int unsigned STEP_BITS      = 4;

    localparam logic [CURVE_MAP_BITS-1:0] CURVE_MAP_RESET = 10'd537;
    localparam logic [DIST_BITS-1:0]      NONE_DISTANCE   = 12'd4064;
    localparam logic [DIST_BITS-1:0]      DIST_MAX        = 12'd4095;

    // Curve codes held in the curve map
    localparam logic [1:0] CURVE_SHORT = 2'd0;
    localparam logic [1:0] CURVE_LONG  = 2'd1;
    localparam logic [1:0] CURVE_BACK  = 2'd2;
    localparam logic [1:0] CURVE_NONE  = 2'd3;

    // Saturation limits of the accumulator
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // Powers of ten for the coefficient rounding
    localparam logic [191:0] E9  = 192'd1_000_000_000;
    localparam logic [191:0] E10 = E9  * 192'd10;
    localparam logic [191:0] E11 = E10 * 192'd10;
    localparam logic [191:0] E12 = E11 * 192'd10;
    localparam logic [191:0] E13 = E12 * 192'd10;
    localparam logic [191:0] E14 = E13 * 192'd10;
    localparam logic [191:0] E15 = E14 * 192'd10;
    localparam logic [191:0] E16 = E15 * 192'd10;
    localparam logic [191:0] E17 = E16 * 192'd10;
    localparam logic [191:0] E18 = E17 * 192'd10;
    localparam logic [191:0] E19 = E18 * 192'd10;
    localparam logic [191:0] E20 = E19 * 192'd10;
    localparam logic [191:0] E21 = E20 * 192'd10;
    localparam logic [191:0] E22 = E21 * 192'd10;
    localparam logic [191:0] E23 = E22 * 192'd10;
    localparam logic [191:0] E24 = E23 * 192'd10;
    localparam logic [191:0] E25 = E24 * 192'd10;
    localparam logic [191:0] E26 = E25 * 192'd10;
    localparam logic [191:0] E27 = E26 * 192'd10;
    localparam logic [191:0] E28 = E27 * 192'd10;
    localparam logic [191:0] E29 = E28 * 192'd10;

    // Short curve, degree 6: round(c_k * 2^(32 + 10k))
    localparam logic signed [63:0] C_S0 =
        64'(((192'd833762148745 << 32) + (E10 >> 1)) / E10);
    localparam logic signed [63:0] C_S1 =
        -64'(((192'd934445496366 << 42) + (E12 >> 1)) / E12);
    localparam logic signed [63:0] C_S2 =
        64'(((192'd548098207662 << 52) + (E14 >> 1)) / E14);
    localparam logic signed [63:0] C_S3 =
        -64'(((192'd181285077491 << 62) + (E16 >> 1)) / E16);
    localparam logic signed [63:0] C_S4 =
        64'(((192'd336401952493 << 72) + (E19 >> 1)) / E19);
    localparam logic signed [63:0] C_S5 =
        -64'(((192'd324803038942 << 82) + (E22 >> 1)) / E22);
    localparam logic signed [63:0] C_S6 =
        64'(((192'd126464293347 << 92) + (E25 >> 1)) / E25);

    // Long curve, degree 8
    localparam logic signed [63:0] C_L0 =
        64'(((192'd485450912561 << 32) + (E9 >> 1)) / E9);
    localparam logic signed [63:0] C_L1 =
        -64'(((192'd602157204247 << 42) + (E11 >> 1)) / E11);
    localparam logic signed [63:0] C_L2 =
        64'(((192'd406130112214 << 52) + (E13 >> 1)) / E13);
    localparam logic signed [63:0] C_L3 =
        -64'(((192'd169401981795 << 62) + (E15 >> 1)) / E15);
    localparam logic signed [63:0] C_L4 =
        64'(((192'd458857846301 << 72) + (E18 >> 1)) / E18);
    localparam logic signed [63:0] C_L5 =
        -64'(((192'd809866506873 << 82) + (E21 >> 1)) / E21);
    localparam logic signed [63:0] C_L6 =
        64'(((192'd897290364989 << 92) + (E24 >> 1)) / E24);
    localparam logic signed [63:0] C_L7 =
        -64'(((192'd564979179032 << 102) + (E27 >> 1)) / E27);
    localparam logic signed [63:0] C_L8 =
        64'(((192'd15358134636 << 112) + (E29 >> 1)) / E29);

    // Back curve, degree 4
    localparam logic signed [63:0] C_B0 =
        64'(((192'd154383035165 << 32) + (E9 >> 1)) / E9);
    localparam logic signed [63:0] C_B1 =
        -64'(((192'd124981836081 << 42) + (E11 >> 1)) / E11);
    localparam logic signed [63:0] C_B2 =
        64'(((192'd454026336693 << 52) + (E14 >> 1)) / E14);
    localparam logic signed [63:0] C_B3 =
        -64'(((192'd753561554655 << 62) + (E17 >> 1)) / E17);
    localparam logic signed [63:0] C_B4 =
        64'(((192'd461115274448 << 72) + (E20 >> 1)) / E20);

    // All curves, each listed from x^0 upward
    localparam logic signed [63:0] COEF_ROM [COEF_COUNT] = '{
        C_S0, C_S1, C_S2, C_S3, C_S4, C_S5, C_S6,
        C_L0, C_L1, C_L2, C_L3, C_L4, C_L5, C_L6, C_L7, C_L8,
        C_B0, C_B1, C_B2, C_B3, C_B4
    };

    // Controller to datapath commands
    typedef struct packed {
        logic                     load;
        logic                     init;
        logic                     mul;
        logic                     add;
        logic                     emit;
        logic [COEF_IDX_BITS-1:0] coef_idx;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] code;
        logic       out_free;
    } t_status;

    function automatic logic signed [ACC_BITS-1:0] f_coef(
        input logic [COEF_IDX_BITS-1:0] idx
    );
        logic signed [ACC_BITS-1:0] v;
        v = '0;
        if (idx < COEF_IDX_BITS'(COEF_COUNT)) begin
            v = COEF_ROM[idx];
        end
        return v;
    endfunction

    function automatic logic [COEF_IDX_BITS-1:0] f_curve_start(input logic [1:0] code);
        logic [COEF_IDX_BITS-1:0] s;
        case (code)
            CURVE_SHORT: s = 5'd0;
            CURVE_LONG:  s = 5'd7;
            CURVE_BACK:  s = 5'd16;
            default:     s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [STEP_BITS-1:0] f_curve_degree(input logic [1:0] code);
        logic [STEP_BITS-1:0] d;
        case (code)
            CURVE_SHORT: d = 4'd6;
            CURVE_LONG:  d = 4'd8;
            CURVE_BACK:  d = 4'd4;
            default:     d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

### sv/irdl_ctrl.sv
// Sequencer of the IR distance linearizer: accept, Horner steps, result handoff.
// Drives the datapath through irdl_pkg::t_cmd and reads irdl_pkg::t_status.
// Depends on irdl_pkg.
module irdl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  irdl_pkg::t_status i_status,
    output irdl_pkg::t_cmd    o_cmd
);
    import irdl_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_k, n_k;

    logic [COEF_IDX_BITS-1:0] start;
    logic [STEP_BITS-1:0]     degree;

    assign start  = f_curve_start(i_status.code);
    assign degree = f_curve_degree(i_status.code);

    // Sequence one transaction at a time
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (i_status.code == CURVE_NONE) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.init     = 1'b1;
                    o_cmd.coef_idx = start + COEF_IDX_BITS'(degree);
                    n_k            = degree;
                    n_state        = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_k       = r_k - 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add      = 1'b1;
                o_cmd.coef_idx = start + COEF_IDX_BITS'(r_k);
                n_state        = (r_k == '0) ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

### sv/irdl_datapath.sv
// Datapath of the IR distance linearizer: channel counter, curve map, Horner
// accumulator with saturating multiply and add, output register.
// Depends on irdl_pkg.
module irdl_datapath #(
    parameter int unsigned CHANNELS    = irdl_pkg::CHANNELS_DEFAULT,
    parameter int unsigned SAMPLE_BITS = irdl_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic                                 i_cfg_we,
    input  logic [irdl_pkg::CURVE_MAP_BITS-1:0]  i_cfg_wdata,
    input  irdl_pkg::t_cmd                       i_cmd,
    output irdl_pkg::t_status                    o_status,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [irdl_pkg::CH_BITS-1:0]         o_channel,
    output logic [irdl_pkg::DIST_BITS-1:0]       o_distance,
    output logic [irdl_pkg::CH_BITS-1:0]         o_next_channel
);
    import irdl_pkg::*;

    localparam int unsigned PROD_BITS = ACC_BITS + SAMPLE_BITS;
    localparam int unsigned Q_BITS    = PROD_MAX_BITS - SCALE_BITS;

    logic [CURVE_MAP_BITS-1:0]  r_curve_map;
    logic [CH_BITS-1:0]         r_ch;
    logic [CH_BITS-1:0]         r_item_ch;
    logic [CH_BITS-1:0]         r_item_next;
    logic [1:0]                 r_code;
    logic [SAMPLE_BITS-1:0]     r_x;
    logic signed [ACC_BITS-1:0] r_acc;
    logic [PROD_BITS-1:0]       r_prod;
    logic                       r_neg;
    logic                       r_out_valid;
    logic [CH_BITS-1:0]         r_out_ch;
    logic [DIST_BITS-1:0]       r_out_dist;
    logic [CH_BITS-1:0]         r_out_next;

    logic [CH_BITS-1:0]         next_ch;
    logic [MAP_EXT_BITS-1:0]    map_ext;
    logic [1:0]                 code;
    logic signed [ACC_BITS-1:0] coef;
    logic [ACC_BITS-1:0]        mag;
    logic [PROD_MAX_BITS-1:0]   prod_ext;
    logic [Q_BITS-1:0]          q;
    logic                       frac;
    logic                       over;
    logic signed [ACC_BITS-1:0] mres;
    logic signed [ACC_BITS:0]   sum;
    logic signed [ACC_BITS-1:0] acc_step;
    logic [DIST_BITS-1:0]       distance;

    // Round-robin channel and the curve code of the current channel
    assign next_ch = (r_ch == CH_BITS'(CHANNELS - 1)) ? '0 : r_ch + 1'b1;
    assign map_ext = MAP_EXT_BITS'(r_curve_map);
    assign code    = map_ext[{r_ch, 1'b0} +: 2];

    assign coef = f_coef(i_cmd.coef_idx);
    assign mag  = r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : ACC_BITS'(r_acc);

    // Scale the product back to Q32 and saturate, flooring negative values, then add the coefficient with saturation
    always_comb begin
        prod_ext = PROD_MAX_BITS'(r_prod);
        q        = prod_ext[PROD_MAX_BITS-1:SCALE_BITS];
        frac     = |prod_ext[SCALE_BITS-1:0];
        over     = |q[Q_BITS-1:ACC_BITS-1];
        if (!r_neg) begin
            mres = over ? ACC_MAX : {1'b0, q[ACC_BITS-2:0]};
        end else if (over || (&q[ACC_BITS-2:0] && frac)) begin
            mres = ACC_MIN;
        end else begin
            mres = ~q[ACC_BITS-1:0] + ACC_BITS'(!frac);
        end
        sum = {mres[ACC_BITS-1], mres} + {coef[ACC_BITS-1], coef};
        if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
            acc_step = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_step = sum[ACC_BITS-1:0];
        end
    end

    // Convert the accumulator to sixteenths of a centimeter
    always_comb begin
        if (r_code == CURVE_NONE) begin
            distance = NONE_DISTANCE;
        end else if (r_acc[ACC_BITS-1]) begin
            distance = '0;
        end else if (|r_acc[ACC_BITS-2:DIST_SHIFT+DIST_BITS]) begin
            distance = DIST_MAX;
        end else begin
            distance = r_acc[DIST_SHIFT+DIST_BITS-1:DIST_SHIFT];
        end
    end

    // Control registers: curve map, channel counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_map <= CURVE_MAP_RESET;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_curve_map <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_ch <= next_ch;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: item capture, Horner accumulator, output
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= i_sample;
            r_item_ch   <= r_ch;
            r_item_next <= next_ch;
            r_code      <= code;
        end
        if (i_cmd.init) begin
            r_acc <= coef;
        end else if (i_cmd.add) begin
            r_acc <= acc_step;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_BITS'(mag) * PROD_BITS'(r_x);
            r_neg  <= r_acc[ACC_BITS-1];
        end
        if (i_cmd.emit) begin
            r_out_ch   <= r_item_ch;
            r_out_dist <= distance;
            r_out_next <= r_item_next;
        end
    end

    assign o_status.code     = r_code;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_channel      = r_out_ch;
    assign o_distance     = r_out_dist;
    assign o_next_channel = r_out_next;

endmodule

### sv/ir_distance_linearizer_top.sv
// Top level of the IR distance linearizer: sequencer plus datapath.
// Depends on irdl_pkg, irdl_ctrl and irdl_datapath.
//
//   channel   direction  signals                                   accepted when
//   sample    in         i_valid, o_ready, i_sample                i_valid && o_ready
//   result    out        o_valid, i_ready, o_channel, o_distance,  o_valid && i_ready
//                        o_next_channel
//   config    in         i_cfg_we, i_cfg_wdata (curve map)         i_cfg_we
//
// One transaction takes the sequencer through ST_IDLE, ST_SETUP, one ST_MUL and
// ST_ADD pair per degree (8 long, 6 short, 4 back) and ST_EMIT; an unused curve
// skips the steps. Each Horner step runs the 64 x SAMPLE_BITS multiplier, then
// the saturating scale-and-add. Synchronous active-low reset clears the
// sequencer, the channel counter (to channel 0) and sets the curve map to 537.
// The result register frees the input side; a new sample is taken while an older
// result waits, and a finished result holds in the datapath until that slot frees.
module ir_distance_linearizer_top #(
    parameter int unsigned CHANNELS    = irdl_pkg::CHANNELS_DEFAULT,
    parameter int unsigned SAMPLE_BITS = irdl_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [irdl_pkg::CH_BITS-1:0]        o_channel,
    output logic [irdl_pkg::DIST_BITS-1:0]      o_distance,
    output logic [irdl_pkg::CH_BITS-1:0]        o_next_channel,
    input  logic                                i_cfg_we,
    input  logic [irdl_pkg::CURVE_MAP_BITS-1:0] i_cfg_wdata
);
    import irdl_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    irdl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath
    irdl_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channel      (o_channel),
        .o_distance     (o_distance),
        .o_next_channel (o_next_channel)
    );

endmodule

### sim/tb_ir_distance_linearizer_top.sv
// Testbench for ir_distance_linearizer_top: a Horner-rule predictor checks the channel,
// distance and next channel of every result against sent samples and curve-map writes.
// Depends on irdl_pkg (curve codes, field widths) and the linearizer RTL.
`timescale 1ns / 1ps

module tb_ir_distance_linearizer_top;
    import irdl_pkg::*;

    localparam int unsigned SENSOR_CHANNELS = 5;
    localparam int unsigned SAMPLE_W        = 10;
    localparam int          LONG_STALL      = 500;
    localparam int          QUIET_LIMIT     = 20000;
    localparam int          SETTLE_CYCLES   = 40;

    localparam logic [DIST_BITS-1:0] UNUSED_RANGE = 12'd4064;
    localparam logic [DIST_BITS-1:0] RANGE_TOP    = 12'd4095;
    localparam logic signed [127:0]  Q32_TOP      = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0]  Q32_BOTTOM   = -Q32_TOP - 128'sd1;

    typedef struct packed {
        logic [CH_BITS-1:0]   channel;
        logic [DIST_BITS-1:0] distance;
        logic [CH_BITS-1:0]   next_channel;
    } t_range_result;

    // DUT ports
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_ready;
    logic [SAMPLE_W-1:0]       i_sample    = '0;
    logic                      o_valid;
    logic                      i_ready     = 1'b0;
    logic [CH_BITS-1:0]        o_channel;
    logic [DIST_BITS-1:0]      o_distance;
    logic [CH_BITS-1:0]        o_next_channel;
    logic                      i_cfg_we    = 1'b0;
    logic [CURVE_MAP_BITS-1:0] i_cfg_wdata = '0;

    // Predictor state and bookkeeping
    logic signed [63:0]        coeff_q32 [21];
    logic [CURVE_MAP_BITS-1:0] curve_map_model = CURVE_MAP_RESET;
    int                        sel_channel     = 0;
    t_range_result             pending_ranges [$];
    int                        curve_hits [4]  = '{0, 0, 0, 0};
    int                        samples_sent    = 0;
    int                        results_checked = 0;
    int                        map_writes      = 0;
    int                        mismatches      = 0;
    int                        sender_idle_pct   = 0;
    int                        receiver_idle_pct = 0;
    int                        stall_requests  = 0;
    int                        stall_granted   = 0;
    int                        stall_left      = 0;
    int                        quiet_cycles    = 0;

    ir_distance_linearizer_top #(
        .CHANNELS    (SENSOR_CHANNELS),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channel      (o_channel),
        .o_distance     (o_distance),
        .o_next_channel (o_next_channel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Decimal curve coefficient of x^k: sign, power of ten below one, mantissa
    function automatic logic signed [63:0] fixed_coeff(input int idx, input int power);
        logic [63:0]  mant;
        logic [7:0]   dexp;
        logic         neg;
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] mag;
        int           i;
        case (idx)
            0:  {neg, dexp, mant} = {1'b0, 8'd10, 64'd833762148745};
            1:  {neg, dexp, mant} = {1'b1, 8'd12, 64'd934445496366};
            2:  {neg, dexp, mant} = {1'b0, 8'd14, 64'd548098207662};
            3:  {neg, dexp, mant} = {1'b1, 8'd16, 64'd181285077491};
            4:  {neg, dexp, mant} = {1'b0, 8'd19, 64'd336401952493};
            5:  {neg, dexp, mant} = {1'b1, 8'd22, 64'd324803038942};
            6:  {neg, dexp, mant} = {1'b0, 8'd25, 64'd126464293347};
            7:  {neg, dexp, mant} = {1'b0, 8'd9,  64'd485450912561};
            8:  {neg, dexp, mant} = {1'b1, 8'd11, 64'd602157204247};
            9:  {neg, dexp, mant} = {1'b0, 8'd13, 64'd406130112214};
            10: {neg, dexp, mant} = {1'b1, 8'd15, 64'd169401981795};
            11: {neg, dexp, mant} = {1'b0, 8'd18, 64'd458857846301};
            12: {neg, dexp, mant} = {1'b1, 8'd21, 64'd809866506873};
            13: {neg, dexp, mant} = {1'b0, 8'd24, 64'd897290364989};
            14: {neg, dexp, mant} = {1'b1, 8'd27, 64'd564979179032};
            15: {neg, dexp, mant} = {1'b0, 8'd29, 64'd15358134636};
            16: {neg, dexp, mant} = {1'b0, 8'd9,  64'd154383035165};
            17: {neg, dexp, mant} = {1'b1, 8'd11, 64'd124981836081};
            18: {neg, dexp, mant} = {1'b0, 8'd14, 64'd454026336693};
            19: {neg, dexp, mant} = {1'b1, 8'd17, 64'd753561554655};
            20: {neg, dexp, mant} = {1'b0, 8'd20, 64'd461115274448};
            default: {neg, dexp, mant} = '0;
        endcase
        // Round half away from zero of mant * 2^(32 + 10k) / 10^dexp
        den = 192'd1;
        for (i = 0; i < dexp; i++) begin
            den = den * 192'd10;
        end
        num = ({128'd0, mant} << (32 + 10 * power)) + (den >> 1);
        mag = num / den;
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic int curve_origin(input logic [1:0] code);
        case (code)
            CURVE_LONG: return 7;
            CURVE_BACK: return 16;
            default:    return 0;
        endcase
    endfunction

    function automatic int curve_order(input logic [1:0] code);
        case (code)
            CURVE_SHORT: return 6;
            CURVE_LONG:  return 8;
            CURVE_BACK:  return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic logic signed [63:0] clamp_q32(input logic signed [127:0] v);
        logic signed [127:0] c;
        c = v;
        if (c > Q32_TOP) c = Q32_TOP;
        if (c < Q32_BOTTOM) c = Q32_BOTTOM;
        return c[63:0];
    endfunction

    // Distance in 1/16 cm from Horner evaluation over t = x / 2^10 in Q32
    function automatic logic [DIST_BITS-1:0] horner_distance(
        input logic [1:0]          code,
        input logic [SAMPLE_W-1:0] x
    );
        logic signed [127:0] wide;
        logic signed [63:0]  acc;
        logic signed [63:0]  coef;
        int                  base;
        int                  k;
        if (code == CURVE_NONE) return UNUSED_RANGE;
        base = curve_origin(code);
        k    = curve_order(code);
        acc  = coeff_q32[base + k];
        while (k > 0) begin
            k--;
            // floor(acc * t) with t = x / 2^10, then the saturating add
            wide = $signed({{64{acc[63]}}, acc}) * $signed({118'd0, x});
            acc  = clamp_q32(wide >>> 10);
            coef = coeff_q32[base + k];
            wide = $signed({{64{acc[63]}}, acc}) + $signed({{64{coef[63]}}, coef});
            acc  = clamp_q32(wide);
        end
        if (acc < 0) return '0;
        if ((acc >>> 28) > 64'sd4095) return RANGE_TOP;
        return acc[39:28];
    endfunction

    // Offer one sample and record the expected result once it is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        t_range_result want;
        logic [1:0]    code;
        int            ch;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= x;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        ch                = sel_channel % SENSOR_CHANNELS;
        code              = curve_map_model[2 * ch +: 2];
        want.channel      = CH_BITS'(ch);
        want.distance     = horner_distance(code, x);
        want.next_channel = CH_BITS'((ch + 1) % SENSOR_CHANNELS);
        pending_ranges.push_back(want);
        sel_channel = (ch + 1) % SENSOR_CHANNELS;
        curve_hits[code]++;
        samples_sent++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_ranges_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_ranges.size() != 0);
    endtask

    task automatic write_curve_map(input logic [CURVE_MAP_BITS-1:0] value);
        wait_ranges_drained();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        curve_map_model  = value;
        map_writes++;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        // Bias about one in eight toward the ends of the converter range
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 1) return 10'h3FF - SAMPLE_W'($urandom_range(0, 1));
            return SAMPLE_W'($urandom_range(0, 1));
        end
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    // Reset curve map: long, back, long, short, back across the five channels
    task automatic test_reset_curve_map();
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(10'd1);
    endtask

    // Every channel on each curve code in turn, at the sample extremes and two mid-range samples
    task automatic test_curve_extremes();
        logic [1:0] cc;
        cc = CURVE_SHORT;
        repeat (4) begin
            write_curve_map({5{cc}});
            send_sample(10'd0);
            send_sample(10'd1023);
            send_sample(10'h155);
            send_sample(10'h2AA);
            send_sample(10'd1);
            cc = cc + 2'd1;
        end
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle);
        int m;
        int n;
        sender_idle_pct   = tx_idle;
        receiver_idle_pct = rx_idle;
        for (m = 0; m < 3; m++) begin
            write_curve_map(CURVE_MAP_BITS'($urandom_range(0, 1023)));
            for (n = 0; n < 75; n++) begin
                send_sample(random_sample());
            end
        end
    endtask

    // Hold off the result side long enough that the input stalls
    task automatic test_output_backpressure();
        int n;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        stall_requests++;
        for (n = 0; n < 40; n++) begin
            send_sample(random_sample());
        end
    endtask

    // Send a burst, pause until all results are back, then resume
    task automatic test_sender_pause();
        int n;
        sender_idle_pct   = 0;
        receiver_idle_pct = 20;
        for (n = 0; n < 10; n++) begin
            send_sample(random_sample());
        end
        wait_ranges_drained();
        for (n = 0; n < 10; n++) begin
            send_sample(random_sample());
        end
    endtask

    // Check each result transaction and drive ready
    always @(posedge i_clk) begin : range_checker
        t_range_result want;
        if (o_valid && i_ready) begin
            if (pending_ranges.size() == 0) begin
                $error("result with no sample pending: channel %0d distance %0d",
                       o_channel, o_distance);
                mismatches++;
            end else begin
                want = pending_ranges.pop_front();
                results_checked++;
                if (o_channel !== want.channel) begin
                    $error("channel: expected %0d, got %0d", want.channel, o_channel);
                    mismatches++;
                end
                if (o_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_distance);
                    mismatches++;
                end
                if (o_next_channel !== want.next_channel) begin
                    $error("next_channel: expected %0d, got %0d",
                           want.next_channel, o_next_channel);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (stall_granted != stall_requests) begin
            stall_granted <= stall_requests;
            stall_left    <= LONG_STALL;
            i_ready       <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [1:0] cc;
        int         k;
        // Build the Q32 coefficient table of all three curves
        for (cc = CURVE_SHORT; cc != CURVE_NONE; cc = cc + 2'd1) begin
            for (k = 0; k <= curve_order(cc); k++) begin
                coeff_q32[curve_origin(cc) + k] = fixed_coeff(curve_origin(cc) + k, k);
            end
        end

        sender_idle_pct   = 8;
        receiver_idle_pct = 78;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_curve_map();
        test_curve_extremes();
        test_random_traffic(8, 78);
        test_random_traffic(78, 8);
        test_random_traffic(0, 0);
        test_output_backpressure();
        test_sender_pause();

        // Let the last results arrive, then allow for any stray output
        wait_ranges_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d samples over %0d curve-map writes",
                 results_checked, samples_sent, map_writes);
        $display("Samples per curve: short %0d, long %0d, back %0d, unused %0d",
                 curve_hits[CURVE_SHORT], curve_hits[CURVE_LONG],
                 curve_hits[CURVE_BACK], curve_hits[CURVE_NONE]);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
